// ----- rtl/core/tcrd_pkg.sv -----
// shared types and constants for the tile column run-length decoder
package tcrd_pkg;

	// field widths
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ROW_W  = 6;
	// run length reaches 256 in reverse order
	localparam int unsigned CNT_W  = 9;

	// code form selector, top two bits of a leading byte
	typedef enum logic [1:0] {
		FORM_LONG  = 2'b00,
		FORM_SHORT = 2'b01,
		FORM_EMPTY = 2'b10,
		FORM_ONE   = 2'b11
	} form_t;

	// field masks of a leading byte
	localparam logic [BYTE_W-1:0] MASK_SHORT_CNT = 8'h30;
	localparam logic [BYTE_W-1:0] MASK_SHORT_TILE = 8'h0F;
	localparam logic [BYTE_W-1:0] MASK_COUNT = 8'h3F;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic step;
	} tcrd_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic count_nz;
		logic slot_free;
		logic last_tile;
	} tcrd_status_t;

endpackage

// ----- rtl/core/tcrd_if.sv -----
// handshake channel interfaces for packed bytes and decoded tiles
interface tcrd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_byte;

	modport source (output valid, output packed_byte, input ready);
	modport sink (input valid, input packed_byte, output ready);
endinterface

interface tcrd_tile_if;
	logic       valid;
	logic       ready;
	logic [7:0] tile;
	logic [5:0] row;
	logic       last_of_run;
	logic       column_end;
	logic       overrun;

	modport source (output valid, output tile, output row, output last_of_run,
		output column_end, output overrun, input ready);
	modport sink (input valid, input tile, input row, input last_of_run,
		input column_end, input overrun, output ready);
endinterface

// ----- rtl/core/tcrd_ctrl.sv -----
// controller state machine: byte acceptance and tile sequencing
module tcrd_ctrl
	import tcrd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  tcrd_status_t st,
	output tcrd_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q, state_d;

	// handshake and commands
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && st.count_nz) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = st.slot_free;
				if (st.slot_free && st.last_tile) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/core/tcrd_dp.sv -----
// datapath: byte decode, run registers, row counter and output word register
module tcrd_dp
	import tcrd_pkg::*;
#(
	parameter int unsigned COLUMN_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic [BYTE_W-1:0] packed_byte,
	input  tcrd_cmd_t         cmd,
	output tcrd_status_t      st,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [BYTE_W-1:0] out_tile,
	output logic [ROW_W-1:0]  out_row,
	output logic              out_last,
	output logic              out_col_end,
	output logic              out_overrun
);

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(COLUMN_ROWS - 1);

	logic              reverse_q;
	logic              awaiting_q;
	logic [BYTE_W-1:0] held_q;
	logic [BYTE_W-1:0] run_tile_q;
	logic [CNT_W-1:0]  remain_q;
	logic [ROW_W-1:0]  row_q;
	logic              out_valid_q;

	logic [BYTE_W-1:0] dec_tile;
	logic [CNT_W-1:0]  dec_count;
	logic              dec_hold;
	form_t             form;
	logic              col_end;
	logic              last_tile;

	assign form = form_t'(packed_byte[BYTE_W-1 -: 2]);

	// decode of the incoming byte
	always_comb begin
		dec_tile  = '0;
		dec_count = '0;
		dec_hold  = 1'b0;
		if (awaiting_q) begin
			if (reverse_q) begin
				dec_tile  = held_q;
				dec_count = {1'b0, packed_byte} + CNT_W'(1);
			end else begin
				dec_tile  = packed_byte;
				dec_count = CNT_W'(held_q & MASK_COUNT) + CNT_W'(1);
			end
		end else begin
			unique case (form)
				FORM_LONG: begin
					dec_hold = 1'b1;
				end
				FORM_SHORT: begin
					dec_tile  = (packed_byte & MASK_SHORT_TILE) + BYTE_W'(1);
					dec_count = CNT_W'((packed_byte & MASK_SHORT_CNT) >> 4) + CNT_W'(2);
				end
				FORM_EMPTY: begin
					dec_tile  = '0;
					dec_count = CNT_W'(packed_byte & MASK_COUNT);
				end
				FORM_ONE: begin
					dec_tile  = packed_byte & MASK_COUNT;
					dec_count = CNT_W'(1);
				end
				default: begin
					dec_hold = 1'b0;
				end
			endcase
		end
	end

	// per-tile flags
	assign col_end   = (row_q == ROW_LAST);
	assign last_tile = col_end || (remain_q == CNT_W'(1));

	assign st.count_nz  = (dec_count != '0);
	assign st.slot_free = !out_valid_q || out_ready;
	assign st.last_tile = last_tile;

	// direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_q <= 1'b0;
		end else if (cfg_we) begin
			reverse_q <= cfg_wdata;
		end
	end

	// pending byte and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			held_q     <= '0;
			row_q      <= '0;
		end else begin
			if (cmd.load) begin
				awaiting_q <= dec_hold;
				if (dec_hold) begin
					held_q <= packed_byte;
				end
			end
			if (cmd.step) begin
				row_q <= col_end ? '0 : row_q + ROW_W'(1);
			end
		end
	end

	// run tile and remaining count
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			run_tile_q <= dec_tile;
			remain_q   <= dec_count;
		end else if (cmd.step) begin
			remain_q <= remain_q - CNT_W'(1);
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_tile    <= run_tile_q;
			out_row     <= row_q;
			out_last    <= last_tile;
			out_col_end <= col_end;
			out_overrun <= col_end && (remain_q != CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/tile_column_rle_decoder.sv -----
// Tile column run-length decoder, top level.
// Flow: a byte is loaded into the run registers; its tile words leave through the output word register.
// Throughput: a byte yields n tiles (n = 0 to 64), one tile a cycle while the output is ready;
//   no new byte is taken until its run ends; the first byte of a pair is only held.
// Reset: arst_n clears the direction, pending byte, row counter, state and output valid.
module tile_column_rle_decoder
	import tcrd_pkg::*;
#(
	parameter int unsigned COLUMN_ROWS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	tcrd_byte_if.sink  bytes_ch,
	tcrd_tile_if.source tiles_ch
);

	tcrd_cmd_t    cmd;
	tcrd_status_t st;

	tcrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bytes_ch.valid),
		.in_ready (bytes_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	tcrd_dp #(
		.COLUMN_ROWS (COLUMN_ROWS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.packed_byte (bytes_ch.packed_byte),
		.cmd         (cmd),
		.st          (st),
		.out_ready   (tiles_ch.ready),
		.out_valid   (tiles_ch.valid),
		.out_tile    (tiles_ch.tile),
		.out_row     (tiles_ch.row),
		.out_last    (tiles_ch.last_of_run),
		.out_col_end (tiles_ch.column_end),
		.out_overrun (tiles_ch.overrun)
	);

	// a column end always closes the run
	a_col_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		tiles_ch.valid && tiles_ch.column_end |-> tiles_ch.last_of_run)
		else $error("column end word without end of run");

	// overrun only on the column end word
	a_overrun_col: assert property (@(posedge clk) disable iff (!arst_n)
		tiles_ch.valid && tiles_ch.overrun |-> tiles_ch.column_end)
		else $error("overrun flagged away from column end");

	// a byte that starts a run blocks further bytes
	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && st.count_nz |=> !bytes_ch.ready)
		else $error("byte accepted while a run is in progress");

	// no tile step while bytes are being accepted
	a_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !bytes_ch.ready)
		else $error("tile step during byte acceptance");

endmodule
